[rtl/dgl_pkg.sv]
// Shared types and constants of the depth-to-gray log tone map.
// No dependencies; used by every design module of the block.
package dgl_pkg;

  localparam logic [1:0] CMD_CLEAR    = 2'd0;
  localparam logic [1:0] CMD_SCAN     = 2'd1;
  localparam logic [1:0] CMD_MAP      = 2'd2;
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_LO_BOUND = 2'd1;
  localparam logic [1:0] REG_HI_BOUND = 2'd2;
  localparam logic [1:0] REG_STRENGTH = 2'd3;

  localparam int unsigned DenW = 57;

  typedef struct packed {
    logic               fmt_unsigned;
    logic signed [23:0] lo_bound;
    logic signed [23:0] hi_bound;
    logic [15:0]        strength;
  } cfg_t;

  // One map job. In float mode diff already holds d - lo (hi - lo for an infinite or NaN sample) and span is one.
  typedef struct packed {
    logic               fmt_unsigned;
    logic signed [33:0] diff;
    logic [31:0]        span;
    logic signed [23:0] lo;
    logic [24:0]        win;
  } job_t;

endpackage

[rtl/dgl_front.sv]
// Front end: accepts items, runs clear and scan on the range registers,
// and turns map items into jobs. Depends on dgl_pkg.
module dgl_front #(
  parameter int unsigned FRAC_BITS = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dgl_pkg::cfg_t      cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         command_i,
  input  logic [31:0]        sample_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output dgl_pkg::job_t      push_job_o
);

  logic [31:0] range_min_q, range_min_d;
  logic [31:0] range_max_q, range_max_d;
  logic        accept;

  logic [7:0]         expo;
  logic [23:0]        mant;
  logic signed [9:0]  sh;
  logic [8:0]         k;
  logic [47:0]        up;
  logic [24:0]        dn;
  logic [47:0]        mag;
  logic signed [24:0] d;
  logic signed [24:0] hi_eff;
  logic signed [25:0] fnum;

  assign in_ready_o   = push_ready_i;
  assign accept       = in_valid_i && push_ready_i;
  assign push_valid_o = in_valid_i && (command_i == dgl_pkg::CMD_MAP);

  always_comb begin
    range_min_d = range_min_q;
    range_max_d = range_max_q;
    if (accept && command_i == dgl_pkg::CMD_CLEAR) begin
      range_min_d = '1;
      range_max_d = '0;
    end else if (accept && command_i == dgl_pkg::CMD_SCAN) begin
      if (sample_i < range_min_q) range_min_d = sample_i;
      if (sample_i > range_max_q) range_max_d = sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_min_q <= '1;
      range_max_q <= '0;
    end else begin
      range_min_q <= range_min_d;
      range_max_q <= range_max_d;
    end
  end

  // Float to saturated fixed point, rounding ties away from zero.
  always_comb begin
    expo = sample_i[30:23];
    mant = {(expo != 8'd0), sample_i[22:0]};
    sh   = $signed({2'b00, (expo != 8'd0) ? expo : 8'd1}) - 10'sd150
           + $signed(10'(FRAC_BITS));
    k    = 9'(-sh);
    up   = 48'(mant) << sh[4:0];
    dn   = '0;
    if (k < 9'd25 && k != 9'd0) begin
      dn = ({1'b0, mant} + (25'd1 << (k - 9'd1))) >> k;
    end
    if (mant == 24'd0) begin
      mag = '0;
    end else if (sh >= 10'sd24) begin
      mag = 48'h1_0000_0000;
    end else if (sh >= 10'sd0) begin
      mag = up;
    end else begin
      mag = 48'(dn);
    end
    if (sample_i[31]) begin
      d = (mag > 48'h80_0000) ? -25'sd8388608 : -$signed(25'(mag));
    end else begin
      d = (mag > 48'h7F_FFFF) ? 25'sd8388607 : $signed(25'(mag));
    end
  end

  always_comb begin
    hi_eff = (cfg_i.hi_bound <= cfg_i.lo_bound) ? 25'(cfg_i.lo_bound) + 25'sd1
                                                : 25'(cfg_i.hi_bound);
    fnum = (expo == 8'hFF) ? 26'(hi_eff) - 26'(cfg_i.lo_bound)
                           : 26'(d) - 26'(cfg_i.lo_bound);
    push_job_o.fmt_unsigned = cfg_i.fmt_unsigned;
    push_job_o.lo           = cfg_i.lo_bound;
    push_job_o.win          = 25'(hi_eff - 25'(cfg_i.lo_bound));
    if (cfg_i.fmt_unsigned) begin
      push_job_o.diff = 34'($signed({1'b0, sample_i}) - $signed({1'b0, range_min_q}));
      push_job_o.span = (range_max_q > range_min_q) ? range_max_q - range_min_q : 32'd1;
    end else begin
      push_job_o.diff = 34'(fnum);
      push_job_o.span = 32'd1;
    end
  end

endmodule

[rtl/dgl_queue.sv]
// Two-entry job queue between front and back end.
// Depends on dgl_pkg for the job type.
module dgl_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  dgl_pkg::job_t push_job_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output dgl_pkg::job_t pop_job_o
);

  dgl_pkg::job_t entry_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_job_o    = entry_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = wr_q ^ do_push;
    rd_d  = rd_q ^ do_pop;
    cnt_d = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_q] <= push_job_i;
  end

endmodule

[rtl/dgl_back.sv]
// Back end: multiplies, ratio division, two log2 passes and the final
// scale to 8 bits, one shared step unit per phase. Depends on dgl_pkg.
module dgl_back #(
  parameter int unsigned FRAC_BITS = 20
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [15:0]   strength_i,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  input  dgl_pkg::job_t pop_job_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    gray_o
);

  localparam int unsigned NumW = (((34 + FRAC_BITS) > 57) ? (34 + FRAC_BITS) : 57) + 1;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_MDEN = 11'b000_0000_0010,
    S_MNUM = 11'b000_0000_0100,
    S_RCHK = 11'b000_0000_1000,
    S_RDIV = 11'b000_0001_0000,
    S_RRND = 11'b000_0010_0000,
    S_XMUL = 11'b000_0100_0000,
    S_NORM = 11'b000_1000_0000,
    S_LOG  = 11'b001_0000_0000,
    S_GDIV = 11'b010_0000_0000,
    S_DONE = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic [7:0] gray_q, gray_d;

  dgl_pkg::job_t job_q, job_d;
  logic [dgl_pkg::DenW-1:0] den_q, den_d;
  logic signed [NumW-1:0]   num_q, num_d;
  logic [57:0] rem_q, rem_d;
  logic [15:0] quo_q, quo_d;
  logic [16:0] t_q, t_d;
  logic        phase_q, phase_d;
  logic [33:0] x_q, x_d;
  logic [30:0] m_q, m_d;
  logic [27:0] r_q, r_d;
  logic [27:0] ld_q, ld_d;
  logic [37:0] gn_q, gn_d;
  logic [8:0]  gq_q, gq_d;
  logic [4:0]  cnt_q, cnt_d;

  logic signed [56:0]     prod;
  logic signed [NumW-1:0] dsh;
  logic signed [NumW-1:0] den_s;
  logic [57:0]  r2;
  logic [15:0]  alpha;
  logic [16:0]  tsel;
  logic [3:0]   p;
  logic [33:0]  mx;
  logic [61:0]  sq;
  logic [31:0]  sqt;
  logic [37:0]  cand;

  assign pop_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign gray_o      = gray_q;

  always_comb begin
    state_d = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    gray_d  = gray_q;
    job_d   = job_q;
    den_d   = den_q;
    num_d   = num_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    t_d     = t_q;
    phase_d = phase_q;
    x_d     = x_q;
    m_d     = m_q;
    r_d     = r_q;
    ld_d    = ld_q;
    gn_d    = gn_q;
    gq_d    = gq_q;
    cnt_d   = cnt_q;

    prod  = $signed(job_q.lo) * $signed({1'b0, job_q.span});
    dsh   = NumW'(job_q.diff) <<< FRAC_BITS;
    den_s = $signed(NumW'(den_q));
    r2    = {rem_q[56:0], 1'b0};
    alpha = (strength_i == 16'd0) ? 16'd256 : strength_i;
    tsel  = phase_q ? t_q : 17'h1_0000;
    sq    = 62'(m_q) * 62'(m_q);
    sqt   = sq[61:30];
    cand  = 38'({ld_q, 1'b0}) << cnt_q[3:0];

    // Leading one of x; x never drops below 2^24.
    p = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (x_q[24 + i]) p = 4'(i);
    end
    mx = (p > 4'd6) ? (x_q >> (p - 4'd6)) : (x_q << (4'd6 - p));

    case (state_q)
      S_IDLE: begin
        if (pop_valid_i) begin
          job_d   = pop_job_i;
          phase_d = 1'b0;
          state_d = S_MDEN;
        end
      end
      S_MDEN: begin
        den_d   = dgl_pkg::DenW'(job_q.span * job_q.win);
        state_d = S_MNUM;
      end
      S_MNUM: begin
        num_d   = job_q.fmt_unsigned ? dsh - NumW'(prod) : NumW'(job_q.diff);
        state_d = S_RCHK;
      end
      S_RCHK: begin
        rem_d = 58'(num_q);
        quo_d = '0;
        cnt_d = '0;
        if (num_q <= 0) begin
          t_d     = '0;
          state_d = S_XMUL;
        end else if (num_q >= den_s) begin
          t_d     = 17'h1_0000;
          state_d = S_XMUL;
        end else begin
          state_d = S_RDIV;
        end
      end
      S_RDIV: begin
        if (r2 >= 58'(den_q)) begin
          rem_d = r2 - 58'(den_q);
          quo_d = {quo_q[14:0], 1'b1};
        end else begin
          rem_d = r2;
          quo_d = {quo_q[14:0], 1'b0};
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd15) state_d = S_RRND;
      end
      S_RRND: begin
        t_d     = 17'(quo_q) + 17'(r2 >= 58'(den_q));
        state_d = S_XMUL;
      end
      S_XMUL: begin
        x_d     = 34'h100_0000 + 34'(alpha * tsel);
        state_d = S_NORM;
      end
      S_NORM: begin
        m_d     = mx[30:0];
        r_d     = {p, 24'd0};
        cnt_d   = 5'd23;
        state_d = S_LOG;
      end
      S_LOG: begin
        if (sqt[31]) begin
          m_d = sqt[31:1];
          r_d[cnt_q] = 1'b1;
        end else begin
          m_d = sqt[30:0];
        end
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          if (!phase_q) begin
            ld_d    = r_d;
            phase_d = 1'b1;
            state_d = S_XMUL;
          end else begin
            gn_d    = 38'(r_d) * 38'd510 + 38'(ld_q);
            gq_d    = '0;
            cnt_d   = 5'd8;
            state_d = S_GDIV;
          end
        end
      end
      S_GDIV: begin
        if (gn_q >= cand) begin
          gn_d = gn_q - cand;
          gq_d[cnt_q[3:0]] = 1'b1;
        end
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          gray_d      = gq_q[8] ? 8'hFF : gq_q[7:0];
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gray_q  <= gray_d;
    job_q   <= job_d;
    den_q   <= den_d;
    num_q   <= num_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    t_q     <= t_d;
    phase_q <= phase_d;
    x_q     <= x_d;
    m_q     <= m_d;
    r_q     <= r_d;
    ld_q    <= ld_d;
    gn_q    <= gn_d;
    gq_q    <= gq_d;
    cnt_q   <= cnt_d;
  end

endmodule

[rtl/depth_to_gray8_log_tone_map.sv]
// Channel | direction | handshake               | payload
// cfg     | in        | cfg_we_i                | cfg_index_i, cfg_data_i
// in      | in        | in_valid_i / in_ready_o | command_i, sample_i
// out     | out       | out_valid_o / out_ready_i | gray_o
// Clear and scan items are handled in the front end. A map item holds the back
// end for a 16-step ratio divider (skipped when the ratio clamps to 0 or 1),
// two 24-step log2 squaring loops on one 31x31 multiplier and a 9-step final
// divider; the back end takes no new job until its result is in the output register.
// Two map jobs can wait in the queue; input stalls only when it is full.
// Reset is asynchronous, active low, and sets the control, range and configuration registers to defaults.
// Holds the configuration registers and ties front end, queue and back end together.
// Depends on dgl_pkg, dgl_front, dgl_queue and dgl_back.
module depth_to_gray8_log_tone_map_core #(
  parameter int unsigned FRAC_BITS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] sample_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  gray_o
);

  dgl_pkg::cfg_t cfg_q, cfg_d;
  dgl_pkg::job_t push_job, pop_job;
  logic push_valid, push_ready, pop_valid, pop_ready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        dgl_pkg::REG_FORMAT:   cfg_d.fmt_unsigned = cfg_data_i[0];
        dgl_pkg::REG_LO_BOUND: cfg_d.lo_bound     = $signed(cfg_data_i);
        dgl_pkg::REG_HI_BOUND: cfg_d.hi_bound     = $signed(cfg_data_i);
        dgl_pkg::REG_STRENGTH: cfg_d.strength     = cfg_data_i[15:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fmt_unsigned <= 1'b0;
      cfg_q.lo_bound     <= 24'sd0;
      cfg_q.hi_bound     <= 24'sd1048576;
      cfg_q.strength     <= 16'd256;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dgl_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i, .rst_ni,
    .cfg_i       (cfg_q),
    .in_valid_i,
    .in_ready_o,
    .command_i,
    .sample_i,
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_job_o  (push_job)
  );

  dgl_queue u_queue (
    .clk_i, .rst_ni,
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_job_i  (push_job),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_job_o   (pop_job)
  );

  dgl_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .strength_i (cfg_q.strength),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_job_i  (pop_job),
    .out_valid_o,
    .out_ready_i,
    .gray_o
  );

endmodule

[rtl/dgl_checker.sv]
// Port-level checks for the tone map core, bound to the top level.
// Depends on depth_to_gray8_log_tone_map_core only.
module dgl_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] gray_o
);

  // The output register is empty while reset is held.
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  a_ready_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown(in_ready_o))
    else $error("input ready unknown");

  a_gray_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !$isunknown(gray_o))
    else $error("gray unknown while valid");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(gray_o))
    else $error("gray changed while stalled");

endmodule

bind depth_to_gray8_log_tone_map_core dgl_checker u_dgl_checker (
  .clk_i, .rst_ni, .in_ready_o,
  .out_valid_o, .out_ready_i, .gray_o
);

[tb/tb.sv]
// Self-checking testbench for depth_to_gray8_log_tone_map_core: a directed table, then
// random phases over several register settings, compared against a bit-exact predictor.
// Depends on dgl_pkg and the core RTL only.
module tb;

  localparam int unsigned FracBits = 20;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned DrainCycles = 120;
  localparam int unsigned PhaseItems = 94;
  localparam int NoCheck = -1;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [23:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  command_i;
  logic [31:0] sample_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  gray_o;

  depth_to_gray8_log_tone_map_core #(.FRAC_BITS(FracBits)) i_dut (.*);

  // Shadow copies of the registers and the scanned range.
  logic        shd_unsigned;
  logic [23:0] shd_lo_bound;
  logic [23:0] shd_hi_bound;
  logic [15:0] shd_strength;
  logic [31:0] range_lo;
  logic [31:0] range_hi;

  logic [7:0] gray_expected[$];
  int unsigned errors = 0;
  int unsigned stall_cycles;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  index;
    logic [23:0] data;
    logic [1:0]  cmd;
    logic [31:0] smp;
    int          gray;
  } stim_row_t;

  localparam int NumRows = 31;
  stim_row_t directed_rows[NumRows] = '{
    '{0, dgl_pkg::REG_FORMAT, 24'd0, dgl_pkg::CMD_MAP, 32'h0000_0000, 0},
    '{0, dgl_pkg::REG_FORMAT, 24'd0, dgl_pkg::CMD_MAP, 32'h3F80_0000, 255},
    '{0, dgl_pkg::REG_FORMAT, 24'd0, dgl_pkg::CMD_MAP, 32'h7F80_0000, 255},
    '{0, dgl_pkg::REG_FORMAT, 24'd0, dgl_pkg::CMD_MAP, 32'h7FC0_0001, 255},
    '{0, dgl_pkg::REG_FORMAT, 24'd0, dgl_pkg::CMD_MAP, 32'hBF80_0000, 0},
    '{0, dgl_pkg::REG_FORMAT, 24'd0, dgl_pkg::CMD_MAP, 32'hFF7F_FFFF, 0},
    '{0, dgl_pkg::REG_FORMAT, 24'd0, dgl_pkg::CMD_MAP, 32'h3F00_0000, NoCheck},
    '{0, dgl_pkg::REG_FORMAT, 24'd0, dgl_pkg::CMD_MAP, 32'h0000_0001, NoCheck},
    '{0, dgl_pkg::REG_FORMAT, 24'd0, dgl_pkg::CMD_RESERVED, 32'hFFFF_FFFF, NoCheck},
    '{0, dgl_pkg::REG_FORMAT, 24'd0, dgl_pkg::CMD_SCAN, 32'h3F80_0000, NoCheck},
    '{1, dgl_pkg::REG_FORMAT, 24'd1, dgl_pkg::CMD_MAP, 32'd0, NoCheck},
    '{0, dgl_pkg::REG_FORMAT, 24'd0, dgl_pkg::CMD_CLEAR, 32'd0, NoCheck},
    '{0, dgl_pkg::REG_FORMAT, 24'd0, dgl_pkg::CMD_MAP, 32'd5, NoCheck},
    '{0, dgl_pkg::REG_FORMAT, 24'd0, dgl_pkg::CMD_SCAN, 32'd100, NoCheck},
    '{0, dgl_pkg::REG_FORMAT, 24'd0, dgl_pkg::CMD_SCAN, 32'd300, NoCheck},
    '{0, dgl_pkg::REG_FORMAT, 24'd0, dgl_pkg::CMD_MAP, 32'd300, 255},
    '{0, dgl_pkg::REG_FORMAT, 24'd0, dgl_pkg::CMD_MAP, 32'd100, 0},
    '{0, dgl_pkg::REG_FORMAT, 24'd0, dgl_pkg::CMD_MAP, 32'd200, NoCheck},
    '{0, dgl_pkg::REG_FORMAT, 24'd0, dgl_pkg::CMD_MAP, 32'hFFFF_FFFF, 255},
    '{0, dgl_pkg::REG_FORMAT, 24'd0, dgl_pkg::CMD_MAP, 32'd0, 0},
    '{1, dgl_pkg::REG_STRENGTH, 24'd0, dgl_pkg::CMD_MAP, 32'd0, NoCheck},
    '{0, dgl_pkg::REG_FORMAT, 24'd0, dgl_pkg::CMD_MAP, 32'd200, NoCheck},
    '{1, dgl_pkg::REG_STRENGTH, 24'h00_FFFF, dgl_pkg::CMD_MAP, 32'd0, NoCheck},
    '{0, dgl_pkg::REG_FORMAT, 24'd0, dgl_pkg::CMD_MAP, 32'd150, NoCheck},
    '{1, dgl_pkg::REG_LO_BOUND, 24'h80_0000, dgl_pkg::CMD_MAP, 32'd0, NoCheck},
    '{1, dgl_pkg::REG_HI_BOUND, 24'h7F_FFFF, dgl_pkg::CMD_MAP, 32'd0, NoCheck},
    '{0, dgl_pkg::REG_FORMAT, 24'd0, dgl_pkg::CMD_MAP, 32'd250, NoCheck},
    '{1, dgl_pkg::REG_HI_BOUND, 24'h80_0000, dgl_pkg::CMD_MAP, 32'd0, NoCheck},
    '{0, dgl_pkg::REG_FORMAT, 24'd0, dgl_pkg::CMD_MAP, 32'd100, NoCheck},
    '{1, dgl_pkg::REG_FORMAT, 24'd0, dgl_pkg::CMD_MAP, 32'd0, NoCheck},
    '{0, dgl_pkg::REG_FORMAT, 24'd0, dgl_pkg::CMD_MAP, 32'h3F80_0000, NoCheck}
  };

  function automatic longint sext_clip(logic [23:0] v);
    return longint'(signed'(v));
  endfunction

  // Finite float32 to saturated fixed point, rounding ties away from zero.
  function automatic longint float_to_clip_fix(logic [31:0] bits);
    longint unsigned mant;
    longint unsigned mag;
    int s;
    int unsigned k;
    mant = {41'd0, bits[22:0]};
    if (bits[30:23] != 8'd0) mant[23] = 1'b1;
    s = int'(bits[30:23] != 8'd0 ? bits[30:23] : 8'd1) - 150 + FracBits;
    if (mant == 0) begin
      mag = 0;
    end else if (s >= 0) begin
      mag = (s >= 40) ? (64'd1 << 40) : (mant << s);
    end else begin
      k = -s;
      mag = (k > 40) ? 0 : ((mant + (64'd1 << (k - 1))) >> k);
    end
    if (bits[31]) return (mag > 64'h80_0000) ? -longint'(64'h80_0000) : -longint'(mag);
    return (mag > 64'h7F_FFFF) ? longint'(64'h7F_FFFF) : longint'(mag);
  endfunction

  // log2 of a Q24 value of at least one, 24 fraction bits, by repeated squaring.
  function automatic longint unsigned log2_fix(longint unsigned x);
    int p;
    longint unsigned m;
    longint unsigned r;
    p = 63;
    while (p > 0 && x[p] == 1'b0) p--;
    m = (p > 30) ? (x >> (p - 30)) : (x << (30 - p));
    r = longint'(p - 24) << 24;
    for (int i = 23; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m >>= 1;
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] predict_gray(logic [31:0] smp);
    longint lo, hi, num, den, span, depth;
    longint unsigned rem, q, alpha, ln, ld, g;
    lo = sext_clip(shd_lo_bound);
    hi = sext_clip(shd_hi_bound);
    if (hi <= lo) hi = lo + 1;
    if (!shd_unsigned) begin
      depth = (smp[30:23] == 8'hFF) ? hi : float_to_clip_fix(smp);
      num = depth - lo;
      den = hi - lo;
    end else begin
      span = (range_hi > range_lo) ? longint'(range_hi) - longint'(range_lo) : 1;
      num = (longint'(smp) - longint'(range_lo)) * (longint'(1) << FracBits) - lo * span;
      den = span * (hi - lo);
    end
    if (num <= 0) begin
      q = 0;
    end else if (num >= den) begin
      q = 65536;
    end else begin
      rem = num;
      q = 0;
      for (int i = 0; i < 16; i++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= longint'(den)) begin
          rem -= den;
          q |= 1;
        end
      end
      if ((rem << 1) >= longint'(den)) q++;
    end
    alpha = (shd_strength != 16'd0) ? shd_strength : 16'd256;
    ln = log2_fix((64'd1 << 24) + alpha * q);
    ld = log2_fix((64'd1 << 24) + alpha * 65536);
    g = (510 * ln + ld) / (2 * ld);
    return (g > 255) ? 8'd255 : g[7:0];
  endfunction

  // Advances the shadow state by one accepted item and queues its result, if any.
  task automatic account_item(logic [1:0] cmd, logic [31:0] smp, int typed_gray);
    logic [7:0] g;
    case (cmd)
      dgl_pkg::CMD_CLEAR: begin
        range_lo = '1;
        range_hi = '0;
      end
      dgl_pkg::CMD_SCAN: begin
        if (smp < range_lo) range_lo = smp;
        if (smp > range_hi) range_hi = smp;
      end
      dgl_pkg::CMD_MAP: begin
        g = predict_gray(smp);
        gray_expected.push_back(typed_gray >= 0 ? typed_gray[7:0] : g);
      end
      default: ;
    endcase
  endtask

  task automatic send_item(logic [1:0] cmd, logic [31:0] smp, int typed_gray);
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    sample_i <= smp;
    do @(posedge clk_i); while (!in_ready_o);
    account_item(cmd, smp, typed_gray);
  endtask

  // Waits until every result is in, then lets trailing clear and scan work settle.
  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (gray_expected.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] index, logic [23:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (index)
      dgl_pkg::REG_FORMAT:   shd_unsigned = data[0];
      dgl_pkg::REG_LO_BOUND: shd_lo_bound = data;
      dgl_pkg::REG_HI_BOUND: shd_hi_bound = data;
      default:               shd_strength = data[15:0];
    endcase
  endtask

  function automatic logic [31:0] random_float();
    logic [31:0] f;
    int unsigned pick;
    pick = $urandom_range(99);
    f = $urandom;
    if (pick < 15) return f;
    if (pick < 20) begin
      f[30:23] = 8'hFF;
      return f;
    end
    f[30:23] = 8'($urandom_range(108, 132));
    f[31] = ($urandom_range(9) == 0);
    return f;
  endfunction

  task automatic run_phase(int unsigned ph);
    int unsigned sent, n;
    logic [23:0] lo, hi;
    logic [31:0] base, spread;
    longint hi_wide;
    drain();
    if (ph == 6) begin
      lo = 24'h80_0000;
      hi = 24'h7F_FFFF;
    end else if (ph == 7) begin
      lo = 24'($urandom_range(0, 1 << 20));
      hi = lo - 24'($urandom_range(0, 1000));
    end else begin
      lo = 24'($urandom_range(0, 1 << 20) - (1 << 19));
      hi_wide = sext_clip(lo) + longint'($urandom_range(1, 1 << 22));
      hi = (hi_wide > 64'sh7F_FFFF) ? 24'h7F_FFFF : hi_wide[23:0];
    end
    write_reg(dgl_pkg::REG_FORMAT, {23'd0, ph[0]});
    write_reg(dgl_pkg::REG_LO_BOUND, lo);
    write_reg(dgl_pkg::REG_HI_BOUND, hi);
    write_reg(dgl_pkg::REG_STRENGTH,
              ph == 2 ? 24'd0 : ph == 3 ? 24'h00_FFFF : {8'd0, 16'($urandom)});
    cfg_we_i <= 1'b0;
    sent = 0;
    while (sent < PhaseItems) begin
      if (!ph[0]) begin
        n = $urandom_range(9);
        if (n == 0) send_item(dgl_pkg::CMD_RESERVED, $urandom, NoCheck);
        else if (n == 1) send_item(dgl_pkg::CMD_SCAN, $urandom, NoCheck);
        else if (n == 2) send_item(dgl_pkg::CMD_CLEAR, $urandom, NoCheck);
        else send_item(dgl_pkg::CMD_MAP, random_float(), NoCheck);
        sent += (n != 0);
      end else begin
        // A frame: usually a clear, scan a few samples, then map samples mostly near that range.
        base = $urandom;
        spread = 32'd1 << $urandom_range(0, 31);
        if ($urandom_range(7) != 0) begin
          send_item(dgl_pkg::CMD_CLEAR, $urandom, NoCheck);
          sent++;
        end
        n = $urandom_range(1, 6);
        repeat (n) send_item(dgl_pkg::CMD_SCAN, base + $urandom_range(0, spread - 1), NoCheck);
        n = $urandom_range(2, 8);
        repeat (n) begin
          if ($urandom_range(9) == 0) send_item(dgl_pkg::CMD_MAP, $urandom, NoCheck);
          else send_item(dgl_pkg::CMD_MAP, base + $urandom_range(0, spread - 1), NoCheck);
        end
        if ($urandom_range(9) == 0) send_item(dgl_pkg::CMD_RESERVED, $urandom, NoCheck);
        sent += 2 * n;
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Output side: random stalls, in-order checking and the no-progress watchdog.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_cycles <= 0;
    end else begin
      out_ready_i <= !(receiver_stall_pct > 0 && $urandom_range(99) < receiver_stall_pct);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("depth_to_gray8_log_tone_map_core verification failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (out_valid_o && out_ready_i) begin
        if (gray_expected.size() == 0) begin
          $error("gray: unexpected transfer, actual %0d", gray_o);
          errors++;
        end else begin
          if (gray_o !== gray_expected[0]) begin
            $error("gray: expected %0d, actual %0d", gray_expected[0], gray_o);
            errors++;
          end
          void'(gray_expected.pop_front());
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = dgl_pkg::REG_FORMAT;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    command_i = dgl_pkg::CMD_CLEAR;
    sample_i = '0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    shd_unsigned = 1'b0;
    shd_lo_bound = 24'd0;
    shd_hi_bound = 24'd1048576;
    shd_strength = 16'd256;
    range_lo = '1;
    range_hi = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int r = 0; r < NumRows; r++) begin
      if (directed_rows[r].is_cfg) begin
        drain();
        write_reg(directed_rows[r].index, directed_rows[r].data);
        cfg_we_i <= 1'b0;
      end else begin
        send_item(directed_rows[r].cmd, directed_rows[r].smp, directed_rows[r].gray);
      end
    end
    for (int unsigned ph = 0; ph < 8; ph++) begin
      sender_idle_pct = (ph % 4 == 1) ? 86 : (ph % 4 == 3) ? 12 : 0;
      receiver_stall_pct = (ph % 4 == 2) ? 86 : (ph % 4 == 3) ? 12 : 0;
      run_phase(ph);
    end
    drain();
    if (errors == 0) begin
      $display("depth_to_gray8_log_tone_map_core verification clean");
    end else begin
      $display("depth_to_gray8_log_tone_map_core verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/dgl_pkg.sv
rtl/dgl_front.sv
rtl/dgl_queue.sv
rtl/dgl_back.sv
rtl/depth_to_gray8_log_tone_map.sv
rtl/dgl_checker.sv
tb/tb.sv
